>>> src/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

  // Default coefficient width (signed Q8.8).
  localparam int COEF_WIDTH_DEF = 16;

  // Roots are signed Q16.16.
  localparam int ROOT_WIDTH = 32;

  // Fraction bits added to the square root of the discriminant.
  localparam int SQRT_FRAC = 16;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_AZERO = 2'd3
  } root_status_t;

endpackage

>>> src/qrs_coef_if.sv
`timescale 1ns / 1ps
interface qrs_coef_if import qrs_pkg::*; #(
  parameter int W = COEF_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

>>> src/qrs_root_if.sv
`timescale 1ns / 1ps
interface qrs_root_if import qrs_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   root_status;
  logic signed [ROOT_WIDTH-1:0] root_plus;
  logic signed [ROOT_WIDTH-1:0] root_minus;
  logic                         saturated;

  modport source (output valid, output root_status, output root_plus, output root_minus,
                  output saturated, input ready);
  modport sink   (input valid, input root_status, input root_plus, input root_minus,
                  input saturated, output ready);
endinterface

>>> src/qrs_sqrt_pipe.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module qrs_sqrt_pipe #(
  parameter int RW = 33,
  parameter int SW = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic            valid [RW];
  logic [2*RW-1:0] rad   [RW];
  logic [RW:0]     rem   [RW];
  logic [RW-1:0]   root  [RW];
  logic [SW-1:0]   side  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic            pv;
    logic [2*RW-1:0] prad;
    logic [RW:0]     prem;
    logic [RW-1:0]   proot;
    logic [SW-1:0]   pside;
    logic [RW+2:0]   remx;
    logic [RW+2:0]   trial;
    logic            fit;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = valid[i-1];
      assign prad  = rad[i-1];
      assign prem  = rem[i-1];
      assign proot = root[i-1];
      assign pside = side[i-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign remx  = {prem, prad[2*RW-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign fit   = remx >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (en) begin
        valid[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i]  <= {prad[2*RW-3:0], 2'b00};
        rem[i]  <= fit ? (RW+1)'(remx - trial) : (RW+1)'(remx);
        root[i] <= {proot[RW-2:0], fit};
        side[i] <= pside;
      end
    end
  end

  assign out_valid = valid[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

>>> src/qrs_div_pipe.sv
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider computing (|n| + a) / (2a), one
// quotient bit per stage; both lanes share the divisor.
module qrs_div_pipe #(
  parameter int W  = 16,
  parameter int SW = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic signed [W+18:0] num_p,
  input  logic signed [W+18:0] num_m,
  input  logic [W-1:0]      am,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  output logic [W+18:0]     quo_p,
  output logic [W+18:0]     quo_m,
  output logic              neg_p,
  output logic              neg_m,
  output logic [SW-1:0]     out_side
);

  localparam int QW = W + 19;

  // Prep stage: magnitudes plus the rounding bias.
  logic          v0;
  logic [QW-1:0] dp0, dm0;
  logic [W:0]    dsr0;
  logic          np0, nm0;
  logic [SW-1:0] side0;
  logic [QW-1:0] magp, magm;

  assign magp = num_p[QW-1] ? QW'(-num_p) : QW'(num_p);
  assign magm = num_m[QW-1] ? QW'(-num_m) : QW'(num_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp0   <= magp + QW'(am);
      dm0   <= magm + QW'(am);
      dsr0  <= {am, 1'b0};
      np0   <= num_p[QW-1];
      nm0   <= num_m[QW-1];
      side0 <= in_side;
    end
  end

  logic          valid [QW];
  logic [QW-1:0] dvdp  [QW];
  logic [QW-1:0] dvdm  [QW];
  logic [W:0]    remp  [QW];
  logic [W:0]    remm  [QW];
  logic [W:0]    dsr   [QW];
  logic          np    [QW];
  logic          nm    [QW];
  logic [SW-1:0] side  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          pv;
    logic [QW-1:0] pdp, pdm;
    logic [W:0]    prp, prm, pdsr;
    logic          pnp, pnm;
    logic [SW-1:0] pside;
    logic [W+1:0]  xp, xm;
    logic          fp, fm;

    if (i == 0) begin : g_first
      assign pv    = v0;
      assign pdp   = dp0;
      assign pdm   = dm0;
      assign prp   = '0;
      assign prm   = '0;
      assign pdsr  = dsr0;
      assign pnp   = np0;
      assign pnm   = nm0;
      assign pside = side0;
    end else begin : g_next
      assign pv    = valid[i-1];
      assign pdp   = dvdp[i-1];
      assign pdm   = dvdm[i-1];
      assign prp   = remp[i-1];
      assign prm   = remm[i-1];
      assign pdsr  = dsr[i-1];
      assign pnp   = np[i-1];
      assign pnm   = nm[i-1];
      assign pside = side[i-1];
    end

    // Shift in the next dividend bit and subtract where it fits.
    assign xp = {prp, pdp[QW-1]};
    assign xm = {prm, pdm[QW-1]};
    assign fp = xp >= {1'b0, pdsr};
    assign fm = xm >= {1'b0, pdsr};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (en) begin
        valid[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remp[i] <= fp ? (W+1)'(xp - {1'b0, pdsr}) : (W+1)'(xp);
        remm[i] <= fm ? (W+1)'(xm - {1'b0, pdsr}) : (W+1)'(xm);
        dvdp[i] <= {pdp[QW-2:0], fp};
        dvdm[i] <= {pdm[QW-2:0], fm};
        dsr[i]  <= pdsr;
        np[i]   <= pnp;
        nm[i]   <= pnm;
        side[i] <= pside;
      end
    end
  end

  assign out_valid = valid[QW-1];
  assign quo_p     = dvdp[QW-1];
  assign quo_m     = dvdm[QW-1];
  assign neg_p     = np[QW-1];
  assign neg_m     = nm[QW-1];
  assign out_side  = side[QW-1];

endmodule

>>> src/quadratic_real_root_solver.sv
`timescale 1ns / 1ps
// Accepts one word per cycle while the output is not stalled; the square root and
// the divider take one bit per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears all valid bits; data registers are not reset.
module quadratic_real_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  qrs_coef_if.sink    in_ch,
  qrs_root_if.source  out_ch
);

  localparam int W  = COEF_WIDTH;
  localparam int DW = 2*W + 2;
  localparam int RW = W + 17;
  localparam int NW = W + 19;
  localparam int QW = W + 19;
  localparam int SS = 2 + 2*W + 2;
  localparam int DS = 3;

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: sign and magnitude of each coefficient.
  logic         s1_valid;
  logic [W-1:0] s1_am, s1_bm, s1_cm;
  logic         s1_sa, s1_sb, s1_sc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sa <= in_ch.coef_a[W-1];
      s1_sb <= in_ch.coef_b[W-1];
      s1_sc <= in_ch.coef_c[W-1];
      s1_am <= in_ch.coef_a[W-1] ? W'(-in_ch.coef_a) : W'(in_ch.coef_a);
      s1_bm <= in_ch.coef_b[W-1] ? W'(-in_ch.coef_b) : W'(in_ch.coef_b);
      s1_cm <= in_ch.coef_c[W-1] ? W'(-in_ch.coef_c) : W'(in_ch.coef_c);
    end
  end

  // Stage 2: products b*b and a*c.
  logic           s2_valid;
  logic [2*W-1:0] s2_bsq, s2_ac;
  logic [W-1:0]   s2_am, s2_bm;
  logic           s2_sa, s2_sb, s2_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bsq  <= s1_bm * s1_bm;
      s2_ac   <= s1_am * s1_cm;
      s2_am   <= s1_am;
      s2_bm   <= s1_bm;
      s2_sa   <= s1_sa;
      s2_sb   <= s1_sb;
      s2_diff <= s1_sa != s1_sc;
    end
  end

  // Stage 3: discriminant and status.
  logic         s3_valid;
  logic [DW-1:0] s3_disc;
  root_status_t s3_status;
  logic [W-1:0] s3_am, s3_bm;
  logic         s3_sa, s3_sb;
  logic [DW-1:0] fac, bsq_x, disc_next;
  logic          disc_neg;
  root_status_t  status_next;

  assign fac   = {s2_ac, 2'b00};
  assign bsq_x = DW'(s2_bsq);

  always_comb begin
    disc_neg  = 1'b0;
    disc_next = bsq_x + fac;
    if (!s2_diff) begin
      disc_neg  = bsq_x < fac;
      disc_next = bsq_x - fac;
    end
    if (s2_am == '0) begin
      status_next = ST_AZERO;
    end else if (disc_neg) begin
      status_next = ST_NONE;
    end else if (disc_next == '0) begin
      status_next = ST_ONE;
    end else begin
      status_next = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_disc   <= disc_next;
      s3_status <= status_next;
      s3_am     <= s2_am;
      s3_bm     <= s2_bm;
      s3_sa     <= s2_sa;
      s3_sb     <= s2_sb;
    end
  end

  // Square root of the discriminant with added fraction bits.
  logic          sq_valid;
  logic [RW-1:0] sq_root;
  logic [SS-1:0] sq_side;

  qrs_sqrt_pipe #(
    .RW (RW),
    .SW (SS)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_rad    ({s3_disc, {(2*SQRT_FRAC){1'b0}}}),
    .in_side   ({s3_status, s3_am, s3_bm, s3_sa, s3_sb}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Numerator stage: -b scaled by the fraction, plus and minus the root.
  logic [1:0]          sq_status;
  logic [W-1:0]        sq_am, sq_bm;
  logic                sq_sa, sq_sb;
  logic signed [NW-1:0] base, rx;

  assign {sq_status, sq_am, sq_bm, sq_sa, sq_sb} = sq_side;
  assign rx   = NW'(sq_root);
  assign base = sq_sb ? NW'({sq_bm, {SQRT_FRAC{1'b0}}}) : -NW'({sq_bm, {SQRT_FRAC{1'b0}}});

  logic                 s4_valid;
  logic signed [NW-1:0] s4_np, s4_nm;
  logic [W-1:0]         s4_am;
  logic [1:0]           s4_status;
  logic                 s4_sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_np     <= base + rx;
      s4_nm     <= base - rx;
      s4_am     <= sq_am;
      s4_status <= sq_status;
      s4_sa     <= sq_sa;
    end
  end

  // Rounded division by 2a.
  logic          dv_valid;
  logic [QW-1:0] dv_qp, dv_qm;
  logic          dv_np, dv_nm;
  logic [DS-1:0] dv_side;

  qrs_div_pipe #(
    .W  (W),
    .SW (DS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .num_p     (s4_np),
    .num_m     (s4_nm),
    .am        (s4_am),
    .in_side   ({s4_status, s4_sa}),
    .out_valid (dv_valid),
    .quo_p     (dv_qp),
    .quo_m     (dv_qm),
    .neg_p     (dv_np),
    .neg_m     (dv_nm),
    .out_side  (dv_side)
  );

  // Output stage: sign, saturation and special cases.
  root_status_t            dv_status;
  logic                    dv_sa;
  logic [QW+32:0]          qpe, qme;
  logic [ROOT_WIDTH-1:0]   rp, rm;
  logic                    satp, satm;
  logic                    negp, negm;

  assign dv_status = root_status_t'(dv_side[2:1]);
  assign dv_sa     = dv_side[0];
  assign qpe       = (QW+33)'(dv_qp);
  assign qme       = (QW+33)'(dv_qm);
  assign negp      = (dv_np != dv_sa) && (qpe != '0);
  assign negm      = (dv_nm != dv_sa) && (qme != '0);

  always_comb begin
    satp = 1'b0;
    if (negp) begin
      if (qpe > (QW+33)'(64'h8000_0000)) begin
        rp   = 32'h8000_0000;
        satp = 1'b1;
      end else begin
        rp = ~qpe[31:0] + 32'd1;
      end
    end else if (qpe > (QW+33)'(64'h7FFF_FFFF)) begin
      rp   = 32'h7FFF_FFFF;
      satp = 1'b1;
    end else begin
      rp = qpe[31:0];
    end
  end

  always_comb begin
    satm = 1'b0;
    if (negm) begin
      if (qme > (QW+33)'(64'h8000_0000)) begin
        rm   = 32'h8000_0000;
        satm = 1'b1;
      end else begin
        rm = ~qme[31:0] + 32'd1;
      end
    end else if (qme > (QW+33)'(64'h7FFF_FFFF)) begin
      rm   = 32'h7FFF_FFFF;
      satm = 1'b1;
    end else begin
      rm = qme[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.root_status <= dv_status;
      if (dv_status == ST_ONE || dv_status == ST_TWO) begin
        out_ch.root_plus  <= rp;
        out_ch.root_minus <= rm;
        out_ch.saturated  <= satp | satm;
      end else begin
        out_ch.root_plus  <= '0;
        out_ch.root_minus <= '0;
        out_ch.saturated  <= 1'b0;
      end
    end
  end

endmodule
